### hdl/assert_macros.svh
// Assertion macros used by grid_raycast_column.
// Bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

### hdl/grc_pkg.sv
// Package for the grid raycaster: constants, register indexes and state type.
// Used by grid_raycast_column; no dependencies.
`default_nettype none
package grc_pkg;
   localparam int MAP_CELLS   = 4096;
   localparam int MAP_AW      = $clog2(MAP_CELLS);
   localparam int SCREEN_COLS = 256;
   localparam int FOV_UNITS   = 652;
   localparam int HALF_FOV    = FOV_UNITS / 2;
   localparam int STEP_SCALE  = 1280;
   localparam int FIRST_STEP  = 4;
   localparam int MARCH_STEPS = 276;
   localparam int MISS_STEP   = FIRST_STEP + MARCH_STEPS;
   localparam int LAST_STEP   = MISS_STEP - 1;
   localparam int DIV_BITS    = 27;
   localparam int DEN_BITS    = 23;
   localparam int SIN_A       = 25736;
   localparam int SIN_B       = 10512;
   localparam int SIN_C       = 1160;

   localparam logic [2:0] CSR_PLAYER_X      = 3'd0;
   localparam logic [2:0] CSR_PLAYER_Z      = 3'd1;
   localparam logic [2:0] CSR_EYE_LIFT      = 3'd2;
   localparam logic [2:0] CSR_VIEW_ANGLE    = 3'd3;
   localparam logic [2:0] CSR_MAP_WIDTH     = 3'd4;
   localparam logic [2:0] CSR_MAP_HEIGHT    = 3'd5;
   localparam logic [2:0] CSR_SCREEN_WIDTH  = 3'd6;
   localparam logic [2:0] CSR_RENDER_HEIGHT = 3'd7;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SINE,
      ST_SPLIT,
      ST_MARCH,
      ST_MULT,
      ST_FINISH
   } state_type;
endpackage
`default_nettype wire

### hdl/grc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module grc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/grid_raycast_column.sv
// Grid raycaster, one screen column per item; map bits held in grc_ram.
// Steps of a column item: offset divide, three sines, step split, march, multiply, wall divide,
// finish; a write item is done when it is accepted.
// Throughput: one item at a time; the march loop, one map read per cycle, sets the rate.
// Reset: synchronous; a clearing pass zeroes all 4096 map cells before items are taken.
`default_nettype none
`include "assert_macros.svh"
module grid_raycast_column (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // cell_index[11:0], cell_solid[12], column[20:13]
   input  wire logic        req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // column_out, ceiling_row, floor_row, wall_shade[25:24]
   input  wire logic        csr_we,
   input  wire logic  [2:0] csr_addr,
   input  wire logic [13:0] csr_wdata
);
   import grc_pkg::*;

   state_type state_ff, state_in;

   logic [13:0] player_x_ff, player_z_ff;
   logic  [7:0] eye_lift_ff, render_height_ff;
   logic [11:0] view_angle_ff;
   logic  [6:0] map_width_ff, map_height_ff;
   logic  [8:0] screen_width_ff;

   logic [MAP_AW-1:0] clr_ff, clr_in;

   logic [DIV_BITS-1:0] num_ff, num_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic  [4:0]         cnt_ff, cnt_in;
   logic                div_wall_ff, div_wall_in;

   logic  [1:0] sin_sel_ff, sin_sel_in;
   logic  [1:0] sin_step_ff, sin_step_in;
   logic [10:0] sin_z_ff, sin_z_in;
   logic [10:0] sin_z2_ff, sin_z2_in;
   logic [14:0] sin_t_ff, sin_t_in;
   logic        sin_neg_ff, sin_neg_in;
   logic signed [15:0] s_ff, s_in, c_ff, c_in;
   logic [14:0] cr_ff, cr_in;

   logic [15:0] sr_x_ff, sr_x_in, sr_z_ff, sr_z_in;
   logic signed [4:0] sq_x_ff, sq_x_in, sq_z_ff, sq_z_in;
   logic signed [15:0] pos_x_ff, pos_x_in, pos_z_ff, pos_z_in;
   logic [10:0] r_x_ff, r_x_in, r_z_ff, r_z_in;
   logic  [8:0] k_ff, k_in;

   logic        chk_vld_ff, chk_vld_in;
   logic        chk_inb_ff, chk_inb_in;
   logic  [8:0] chk_k_ff, chk_k_in;
   logic  [7:0] chk_bx_ff, chk_bx_in, chk_bz_ff, chk_bz_in;

   logic  [8:0] hitk_ff, hitk_in;
   logic  [1:0] shade_ff, shade_in;
   logic  [7:0] col_ff, col_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic              ram_we, ram_wdata, ram_rdata;
   logic [MAP_AW-1:0] ram_waddr, ram_raddr;

   logic        req_acc;
   logic  [7:0] req_col;
   logic  [8:0] eff_w;
   logic [23:0] div_trial;
   logic  [9:0] off;
   logic [11:0] ray, rel, sin_ang;
   logic [10:0] z0;
   logic [14:0] mul_a;
   logic [10:0] mul_b;
   logic [25:0] prod;
   logic [15:0] prod_sh;
   logic [11:0] step_rx, step_rz;
   logic        carry_x, carry_z;
   logic  [6:0] cx, cz;
   logic [14:0] idx;
   logic        inb, issue, hit;
   logic  [8:0] dx, dz, ndx, ndz;
   logic        vert;
   logic [23:0] den_prod;
   logic [11:0] wh;
   logic signed [12:0] hdiff, half;
   logic signed [13:0] ceil_s;
   logic  [7:0] ceil_row;

   grc_ram #(.WIDTH(1), .DEPTH(MAP_CELLS)) u_map (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign req_col    = req_tdata[20:13];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_x_ff      <= '0;
         player_z_ff      <= '0;
         eye_lift_ff      <= '0;
         view_angle_ff    <= '0;
         map_width_ff     <= 7'd16;
         map_height_ff    <= 7'd16;
         screen_width_ff  <= 9'd80;
         render_height_ff <= 8'd24;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_PLAYER_X:      player_x_ff      <= csr_wdata;
            CSR_PLAYER_Z:      player_z_ff      <= csr_wdata;
            CSR_EYE_LIFT:      eye_lift_ff      <= csr_wdata[7:0];
            CSR_VIEW_ANGLE:    view_angle_ff    <= csr_wdata[11:0];
            CSR_MAP_WIDTH:     map_width_ff     <= csr_wdata[6:0];
            CSR_MAP_HEIGHT:    map_height_ff    <= csr_wdata[6:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[8:0];
            CSR_RENDER_HEIGHT: render_height_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff      <= num_in;
      den_ff      <= den_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      div_wall_ff <= div_wall_in;
      sin_sel_ff  <= sin_sel_in;
      sin_step_ff <= sin_step_in;
      sin_z_ff    <= sin_z_in;
      sin_z2_ff   <= sin_z2_in;
      sin_t_ff    <= sin_t_in;
      sin_neg_ff  <= sin_neg_in;
      s_ff        <= s_in;
      c_ff        <= c_in;
      cr_ff       <= cr_in;
      sr_x_ff     <= sr_x_in;
      sr_z_ff     <= sr_z_in;
      sq_x_ff     <= sq_x_in;
      sq_z_ff     <= sq_z_in;
      pos_x_ff    <= pos_x_in;
      pos_z_ff    <= pos_z_in;
      r_x_ff      <= r_x_in;
      r_z_ff      <= r_z_in;
      k_ff        <= k_in;
      chk_inb_ff  <= chk_inb_in;
      chk_k_ff    <= chk_k_in;
      chk_bx_ff   <= chk_bx_in;
      chk_bz_ff   <= chk_bz_in;
      hitk_ff     <= hitk_in;
      shade_ff    <= shade_in;
      col_ff      <= col_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      div_wall_in  = div_wall_ff;
      sin_sel_in   = sin_sel_ff;
      sin_step_in  = sin_step_ff;
      sin_z_in     = sin_z_ff;
      sin_z2_in    = sin_z2_ff;
      sin_t_in     = sin_t_ff;
      sin_neg_in   = sin_neg_ff;
      s_in         = s_ff;
      c_in         = c_ff;
      cr_in        = cr_ff;
      sr_x_in      = sr_x_ff;
      sr_z_in      = sr_z_ff;
      sq_x_in      = sq_x_ff;
      sq_z_in      = sq_z_ff;
      pos_x_in     = pos_x_ff;
      pos_z_in     = pos_z_ff;
      r_x_in       = r_x_ff;
      r_z_in       = r_z_ff;
      k_in         = k_ff;
      hitk_in      = hitk_ff;
      shade_in     = shade_ff;
      col_in       = col_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_we       = 1'b0;
      ram_waddr    = req_tdata[MAP_AW-1:0];
      ram_wdata    = req_tdata[12];

      eff_w     = (screen_width_ff > 9'(SCREEN_COLS)) ? 9'(SCREEN_COLS) : screen_width_ff;
      div_trial = {rem_ff, num_ff[DIV_BITS-1]};

      off = num_ff[9:0];
      ray = 12'(view_angle_ff + 12'(4096 - HALF_FOV) + {2'b0, off});
      rel = 12'({2'b0, off} + 12'(4096 - HALF_FOV));
      case (sin_sel_ff)
         2'd0:    sin_ang = ray;
         2'd1:    sin_ang = 12'(ray + 12'd1024);
         default: sin_ang = 12'(rel + 12'd1024);
      endcase
      z0 = sin_ang[10] ? 11'(11'd1024 - {1'b0, sin_ang[9:0]}) : {1'b0, sin_ang[9:0]};
      case (sin_step_ff)
         2'd0:    begin mul_a = {4'b0, z0};       mul_b = z0;        end
         2'd1:    begin mul_a = 15'(SIN_C);       mul_b = sin_z2_ff; end
         2'd2:    begin mul_a = sin_t_ff;         mul_b = sin_z2_ff; end
         default: begin mul_a = sin_t_ff;         mul_b = sin_z_ff;  end
      endcase
      prod    = 26'(mul_a) * 26'(mul_b);
      prod_sh = prod[25:10];

      step_rx = {1'b0, r_x_ff} + {1'b0, sr_x_ff[10:0]};
      step_rz = {1'b0, r_z_ff} + {1'b0, sr_z_ff[10:0]};
      carry_x = (step_rx >= 12'(STEP_SCALE));
      carry_z = (step_rz >= 12'(STEP_SCALE));
      cx      = pos_x_ff[14:8];
      cz      = pos_z_ff[14:8];
      idx     = 15'(cz) * 15'(map_width_ff) + {8'b0, cx};
      inb     = !pos_x_ff[15] && !pos_z_ff[15] && (cx < map_width_ff)
                && (cz < map_height_ff) && (idx < 15'(MAP_CELLS));
      ram_raddr = idx[MAP_AW-1:0];
      issue   = (state_ff == ST_MARCH) && (k_ff >= 9'(FIRST_STEP))
                && (k_ff <= 9'(LAST_STEP));
      chk_vld_in = issue;
      chk_inb_in = inb;
      chk_k_in   = k_ff;
      chk_bx_in  = pos_x_ff[7:0];
      chk_bz_in  = pos_z_ff[7:0];
      hit        = chk_vld_ff && chk_inb_ff && ram_rdata;

      ndx  = 9'(9'd256 - {1'b0, chk_bx_ff});
      ndz  = 9'(9'd256 - {1'b0, chk_bz_ff});
      dx   = ({1'b0, chk_bx_ff} < ndx) ? {1'b0, chk_bx_ff} : ndx;
      dz   = ({1'b0, chk_bz_ff} < ndz) ? {1'b0, chk_bz_ff} : ndz;
      vert = (dx < dz);

      den_prod = 24'(hitk_ff) * 24'(cr_ff) + 24'd32768;

      wh     = num_ff[11:0];
      hdiff  = $signed({5'b0, render_height_ff}) - $signed({1'b0, wh});
      half   = (hdiff + $signed({12'b0, hdiff[12]})) >>> 1;
      ceil_s = $signed({half[12], half}) - $signed({6'b0, eye_lift_ff});
      ceil_row = ceil_s[13] ? 8'd0 : ceil_s[7:0];

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 1'b0;
            clr_in    = MAP_AW'(clr_ff + 1'b1);
            if (clr_ff == MAP_AW'(MAP_CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               if (req_tuser == OP_WRITE) begin
                  ram_we = 1'b1;
               end else if ({1'b0, req_col} < eff_w) begin
                  col_in      = req_col;
                  num_in      = DIV_BITS'(18'(req_col) * 18'(FOV_UNITS));
                  den_in      = DEN_BITS'(eff_w);
                  rem_in      = '0;
                  cnt_in      = '0;
                  div_wall_in = 1'b0;
                  state_in    = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            if (div_trial >= {1'b0, den_ff}) begin
               rem_in = DEN_BITS'(div_trial - {1'b0, den_ff});
               num_in = {num_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = div_trial[DEN_BITS-1:0];
               num_in = {num_ff[DIV_BITS-2:0], 1'b0};
            end
            cnt_in = 5'(cnt_ff + 1'b1);
            if (cnt_ff == 5'(DIV_BITS - 1)) begin
               if (div_wall_ff) begin
                  state_in = ST_FINISH;
               end else begin
                  sin_sel_in  = 2'd0;
                  sin_step_in = 2'd0;
                  state_in    = ST_SINE;
               end
            end
         end
         ST_SINE: begin
            sin_step_in = 2'(sin_step_ff + 1'b1);
            case (sin_step_ff)
               2'd0: begin
                  sin_z_in   = z0;
                  sin_z2_in  = prod_sh[10:0];
                  sin_neg_in = sin_ang[11];
               end
               2'd1: sin_t_in = 15'(14'(SIN_B) - prod_sh[13:0]);
               2'd2: sin_t_in = 15'(SIN_A) - prod_sh[14:0];
               default: begin
                  case (sin_sel_ff)
                     2'd0: s_in = sin_neg_ff ? -$signed({1'b0, prod_sh[14:0]})
                                             : $signed({1'b0, prod_sh[14:0]});
                     2'd1: c_in = sin_neg_ff ? -$signed({1'b0, prod_sh[14:0]})
                                             : $signed({1'b0, prod_sh[14:0]});
                     default: cr_in = sin_neg_ff ? 15'd0 : prod_sh[14:0];
                  endcase
                  sin_sel_in = 2'(sin_sel_ff + 1'b1);
                  if (sin_sel_ff == 2'd2) begin
                     sr_x_in  = 16'(s_ff + 16'sd16640);
                     sr_z_in  = 16'(c_ff + 16'sd16640);
                     sq_x_in  = -5'sd13;
                     sq_z_in  = -5'sd13;
                     state_in = ST_SPLIT;
                  end
               end
            endcase
         end
         ST_SPLIT: begin
            if (sr_x_ff >= 16'(STEP_SCALE)) begin
               sr_x_in = 16'(sr_x_ff - 16'(STEP_SCALE));
               sq_x_in = sq_x_ff + 5'sd1;
            end
            if (sr_z_ff >= 16'(STEP_SCALE)) begin
               sr_z_in = 16'(sr_z_ff - 16'(STEP_SCALE));
               sq_z_in = sq_z_ff + 5'sd1;
            end
            if (sr_x_ff < 16'(STEP_SCALE) && sr_z_ff < 16'(STEP_SCALE)) begin
               pos_x_in = $signed({2'b0, player_x_ff});
               pos_z_in = $signed({2'b0, player_z_ff});
               r_x_in   = '0;
               r_z_in   = '0;
               k_in     = '0;
               state_in = ST_MARCH;
            end
         end
         ST_MARCH: begin
            r_x_in   = carry_x ? 11'(step_rx - 12'(STEP_SCALE)) : step_rx[10:0];
            r_z_in   = carry_z ? 11'(step_rz - 12'(STEP_SCALE)) : step_rz[10:0];
            pos_x_in = pos_x_ff + 16'(sq_x_ff) + $signed({15'b0, carry_x});
            pos_z_in = pos_z_ff + 16'(sq_z_ff) + $signed({15'b0, carry_z});
            k_in     = 9'(k_ff + 1'b1);
            if (hit) begin
               hitk_in = chk_k_ff;
               if (chk_k_ff <= 9'd70) begin
                  shade_in = vert ? 2'd2 : 2'd3;
               end else if (chk_k_ff <= 9'd150) begin
                  shade_in = vert ? 2'd1 : 2'd2;
               end else if (chk_k_ff <= 9'd190) begin
                  shade_in = 2'd1;
               end else begin
                  shade_in = vert ? 2'd0 : 2'd1;
               end
               state_in = ST_MULT;
            end else if (chk_vld_ff && chk_k_ff == 9'(LAST_STEP)) begin
               hitk_in  = 9'(MISS_STEP);
               shade_in = 2'd0;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            den_in      = den_prod[DEN_BITS-1:0];
            num_in      = (DIV_BITS'(render_height_ff) << 18)
                          + (DIV_BITS'(render_height_ff) << 16);
            rem_in      = '0;
            cnt_in      = '0;
            div_wall_in = 1'b1;
            state_in    = ST_DIV;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, shade_ff, 8'(render_height_ff - ceil_row),
                               ceil_row, col_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_ALWAYS(a_no_write_in_march, clock, reset, !(state_ff == ST_MARCH && ram_we))
   `ASSERT_IMPLY(a_hit_step_range, clock, reset, state_ff == ST_MARCH && hit,
      chk_k_ff >= 9'(FIRST_STEP) && chk_k_ff <= 9'(LAST_STEP))
   `ASSERT_IMPLY(a_wall_bound, clock, reset, state_ff == ST_FINISH,
      {4'b0, num_ff[11:0]} <= 16'(render_height_ff) * 16'd10 && num_ff[26:12] == '0)
endmodule
`default_nettype wire

### tb/tb_grid_raycast_column.sv
// Self-checking testbench for grid_raycast_column: map writes and column renders on a stream.
// Holds its own column predictor and map copy; depends on grc_pkg and the block only.
`timescale 1ns / 100ps
module tb_grid_raycast_column;
   import grc_pkg::*;

   typedef struct {
      logic        op;
      logic [11:0] idx;
      logic        solid;
      logic [7:0]  col;
   } req_item_t;

   typedef struct {
      logic [7:0] col;
      logic [7:0] ceil_row;
      logic [7:0] floor_row;
      logic [1:0] shade;
   } column_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // cell_index, cell_solid, column
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // column_out, ceiling_row, floor_row, wall_shade
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [13:0] csr_wdata = '0;

   grid_raycast_column dut (.*);

   initial forever #6 clock = ~clock;

   req_item_t pending[$];
   column_t   columns_due[$];
   int        fails = 0;
   int        cyc = 0;
   int        quiet = 0;

   int unsigned px, pz, eye, heading, mw, mh, sw, rh;
   bit          cells[MAP_CELLS];

   function automatic int sine_q14(int unsigned a);
      int unsigned q, r, z, z2, t;
      a &= 4095;
      q = a >> 10;
      r = a & 1023;
      z = (q & 1) ? 1024 - r : r;
      z2 = (z * z) >> 10;
      t = (SIN_C * z2) >> 10;
      t = SIN_B - t;
      t = (t * z2) >> 10;
      t = SIN_A - t;
      t = (t * z) >> 10;
      return (q >= 2) ? -int'(t) : int'(t);
   endfunction

   function automatic bit solid_at(longint hx, longint hz);
      longint cx, cz, ci;
      if (hx < 0 || hz < 0) return 0;
      cx = (hx / STEP_SCALE) >> 8;
      cz = (hz / STEP_SCALE) >> 8;
      if (cx >= mw || cz >= mh) return 0;
      ci = cz * mw + cx;
      if (ci >= MAP_CELLS) return 0;
      return cells[ci];
   endfunction

   function automatic bit render_column(req_item_t it, output column_t res);
      int unsigned w, off, ray, rel, k, hitk, shade, bx, bz, dx, dz;
      int          s, c, cr;
      longint      hx, hz, den, wh, half, ceil_row;
      bit          vert;
      if (it.op == OP_WRITE) begin
         cells[it.idx] = it.solid;
         return 0;
      end
      w = (sw > SCREEN_COLS) ? SCREEN_COLS : sw;
      if (it.col >= w) return 0;
      off = (it.col * FOV_UNITS) / w;
      ray = (heading + 4096 - HALF_FOV + off) & 4095;
      s = sine_q14(ray);
      c = sine_q14(ray + 1024);
      hitk = MISS_STEP;
      shade = 0;
      for (k = FIRST_STEP; k < MISS_STEP; k++) begin
         hx = longint'(px) * STEP_SCALE + longint'(s) * k;
         hz = longint'(pz) * STEP_SCALE + longint'(c) * k;
         if (solid_at(hx, hz)) begin
            bx = (hx / STEP_SCALE) & 255;
            bz = (hz / STEP_SCALE) & 255;
            dx = (bx < 256 - bx) ? bx : 256 - bx;
            dz = (bz < 256 - bz) ? bz : 256 - bz;
            vert = dx < dz;
            if (k <= 70) shade = vert ? 2 : 3;
            else if (k <= 150) shade = vert ? 1 : 2;
            else if (k <= 190) shade = 1;
            else shade = vert ? 0 : 1;
            hitk = k;
            break;
         end
      end
      rel = (off + 4096 - HALF_FOV) & 4095;
      cr = sine_q14(rel + 1024);
      if (cr < 0) cr = 0;
      den = longint'(hitk) * cr + 32768;
      wh = (longint'(20) * 16384 * rh) / den;
      half = (longint'(rh) - wh) / 2;
      ceil_row = half - eye;
      if (ceil_row < 0) ceil_row = 0;
      res.col = it.col;
      res.ceil_row = ceil_row[7:0];
      res.floor_row = 8'(longint'(rh) - ceil_row);
      res.shade = shade[1:0];
      return 1;
   endfunction

   function automatic bit calm();
      return cyc >= 60000 && cyc < 160000;
   endfunction

   // driver
   always @(posedge clock) begin
      req_item_t it;
      cyc <= cyc + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending.size() > 0 && (calm() || $urandom_range(0, 99) >= 26)) begin
            it = pending.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= it.op;
            req_tdata <= {3'b000, it.col, it.solid, it.idx};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      req_item_t it;
      column_t   res, want;
      bit        moved;
      moved = 1'b0;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm() || $urandom_range(0, 99) >= 26;
         if (req_tvalid && req_tready) begin
            moved = 1'b1;
            it.op = req_tuser;
            it.idx = req_tdata[11:0];
            it.solid = req_tdata[12];
            it.col = req_tdata[20:13];
            if (render_column(it, res)) columns_due.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (columns_due.size() == 0) begin
               $error("unexpected column result %h", rsp_tdata);
               fails++;
            end else begin
               want = columns_due.pop_front();
               if (rsp_tdata[7:0] !== want.col) begin
                  $error("column_out exp %0d got %0d", want.col, rsp_tdata[7:0]);
                  fails++;
               end
               if (rsp_tdata[15:8] !== want.ceil_row) begin
                  $error("ceiling_row exp %0d got %0d", want.ceil_row, rsp_tdata[15:8]);
                  fails++;
               end
               if (rsp_tdata[23:16] !== want.floor_row) begin
                  $error("floor_row exp %0d got %0d", want.floor_row, rsp_tdata[23:16]);
                  fails++;
               end
               if (rsp_tdata[25:24] !== want.shade) begin
                  $error("wall_shade exp %0d got %0d", want.shade, rsp_tdata[25:24]);
                  fails++;
               end
            end
         end
         quiet <= moved ? 0 : quiet + 1;
         if (quiet > 40000) begin
            $display("grid_raycast_column regression: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(logic [2:0] a, int unsigned v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= v[13:0];
      case (a)
         CSR_PLAYER_X:      px = v & 16'h3FFF;
         CSR_PLAYER_Z:      pz = v & 16'h3FFF;
         CSR_EYE_LIFT:      eye = v & 8'hFF;
         CSR_VIEW_ANGLE:    heading = v & 12'hFFF;
         CSR_MAP_WIDTH:     mw = v & 7'h7F;
         CSR_MAP_HEIGHT:    mh = v & 7'h7F;
         CSR_SCREEN_WIDTH:  sw = v & 9'h1FF;
         CSR_RENDER_HEIGHT: rh = v & 8'hFF;
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending.size() > 0 || req_tvalid || columns_due.size() > 0) @(posedge clock);
      repeat (500) @(posedge clock);
   endtask

   task automatic put(logic op, int unsigned idx, logic solid, int unsigned col);
      req_item_t it;
      it.op = op;
      it.idx = idx[11:0];
      it.solid = solid;
      it.col = col[7:0];
      pending.push_back(it);
   endtask

   task automatic put_col(int unsigned col);
      put(OP_RENDER, $urandom_range(0, 4095), $urandom_range(0, 1), col);
   endtask

   task automatic put_cell(int unsigned idx, logic solid);
      put(OP_WRITE, idx, solid, $urandom_range(0, 255));
   endtask

   initial begin
      int unsigned w, h, n;
      px = 0; pz = 0; eye = 0; heading = 0; mw = 16; mh = 16; sw = 80; rh = 24;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, edges of the map and screen
      put_cell(0, 1);
      put_cell(4095, 1);
      put_cell(17, 1);
      put_cell(17, 0);
      put_cell(34, 1);
      put_col(0);
      put_col(79);
      put_col(80);
      put_col(255);
      drain();
      write_reg(CSR_PLAYER_X, 16383);
      write_reg(CSR_PLAYER_Z, 16383);
      write_reg(CSR_EYE_LIFT, 255);
      write_reg(CSR_VIEW_ANGLE, 4095);
      write_reg(CSR_MAP_WIDTH, 127);
      write_reg(CSR_MAP_HEIGHT, 127);
      write_reg(CSR_SCREEN_WIDTH, 511);
      write_reg(CSR_RENDER_HEIGHT, 255);
      end_writes();
      put_col(0);
      put_col(255);
      put_col(128);
      drain();
      write_reg(CSR_PLAYER_X, 384);
      write_reg(CSR_PLAYER_Z, 384);
      write_reg(CSR_EYE_LIFT, 0);
      write_reg(CSR_MAP_WIDTH, 0);
      write_reg(CSR_SCREEN_WIDTH, 256);
      write_reg(CSR_RENDER_HEIGHT, 1);
      end_writes();
      put_col(0);
      put_col(255);
      drain();
      write_reg(CSR_MAP_WIDTH, 16);
      write_reg(CSR_SCREEN_WIDTH, 0);
      end_writes();
      put_col(0);
      put_col(5);
      drain();

      // random rooms: border walls (none in phase 3, a 64x64 map), scattered blocks, stray writes, then columns
      for (int ph = 0; ph < 9; ph++) begin
         w = $urandom_range(3, 12);
         h = $urandom_range(3, 12);
         if (ph == 3) begin w = 64; h = 64; end
         write_reg(CSR_MAP_WIDTH, (ph == 5) ? $urandom_range(65, 127) : w);
         write_reg(CSR_MAP_HEIGHT, (ph == 7) ? 0 : h);
         write_reg(CSR_PLAYER_X, (ph == 6) ? $urandom_range(0, 16383)
                                 : $urandom_range(256, w * 256 - 257));
         write_reg(CSR_PLAYER_Z, (ph == 6) ? $urandom_range(0, 16383)
                                 : $urandom_range(256, h * 256 - 257));
         write_reg(CSR_EYE_LIFT, (ph % 3 == 0) ? 0 : $urandom_range(0, 255));
         write_reg(CSR_VIEW_ANGLE, $urandom_range(0, 4095));
         n = $urandom_range(1, 256);
         if (ph == 2) n = 256;
         if (ph == 4) n = 1;
         write_reg(CSR_SCREEN_WIDTH, n);
         write_reg(CSR_RENDER_HEIGHT, (ph == 1) ? 255 : $urandom_range(1, 255));
         end_writes();
         if (ph != 3) begin
            for (int i = 0; i < int'(w); i++) begin
               put_cell(i, 1);
               put_cell((h - 1) * w + i, 1);
            end
            for (int j = 1; j < int'(h) - 1; j++) begin
               put_cell(j * w, 1);
               put_cell(j * w + w - 1, 1);
            end
            for (int i = 0; i < 8; i++) put_cell($urandom_range(0, w * h - 1), $urandom_range(0, 1));
         end else begin
            for (int i = 0; i < 40; i++) put_cell($urandom_range(0, 4095), $urandom_range(0, 1));
         end
         for (int i = 0; i < 4; i++) put_cell($urandom_range(0, 4095), $urandom_range(0, 1));
         for (int i = 0; i < 110; i++)
            put_col(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, sw - 1));
         drain();
      end

      if (fails == 0) begin
         $display("grid_raycast_column regression: pass");
      end else begin
         $display("grid_raycast_column regression: fail");
      end
      $finish;
   end
endmodule

### sim.f
+incdir+hdl
hdl/grc_pkg.sv
hdl/grc_ram.sv
hdl/grid_raycast_column.sv
tb/tb_grid_raycast_column.sv
